[rtl/core/note_snapshot_frame_parser_top_defines.svh]
// Assertion macros shared by the note snapshot parser RTL.
// No dependencies; included by modules that carry assertions.
`ifndef NOTE_SNAPSHOT_FRAME_PARSER_TOP_DEFINES_SVH
`define NOTE_SNAPSHOT_FRAME_PARSER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define NSFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsfp assertion failed");
// Implication checked in the cycle after the antecedent.
`define NSFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsfp assertion failed");
`endif

[rtl/core/nsfp_pkg.sv]
// Shared types and constants of the note snapshot frame parser.
// No dependencies.
package nsfp_pkg;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [3:0] KIND_VERSION = 4'd0;
  localparam logic [3:0] KIND_COUNT   = 4'd1;
  localparam logic [3:0] KIND_LEN0    = 4'd2;
  localparam logic [3:0] KIND_ORDER   = 4'd5;
  localparam logic [3:0] KIND_TIME    = 4'd6;
  localparam logic [3:0] KIND_FLAGS   = 4'd7;
  localparam logic [3:0] KIND_TEXT0   = 4'd8;
  localparam logic [3:0] KIND_STATUS  = 4'd11;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_CRC   = 3'd2;
  localparam logic [2:0] ST_SCHEMA = 3'd3;
  localparam logic [2:0] ST_COUNT = 3'd4;
  localparam logic [2:0] ST_LONG  = 3'd5;
  localparam logic [2:0] ST_TRUNC = 3'd6;
  localparam logic [2:0] ST_TRAIL = 3'd7;

  // One classified request from the front part to the back part.
  typedef struct packed {
    logic       feed;     // a payload byte leaves the delay line
    logic [7:0] leave;    // that byte
    logic       last;     // frame ends with this request
    logic       short_fr; // ended before four bytes were seen
    logic [31:0] rx_crc;  // trailer as received, valid on last
  } nsfp_req_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  note_index;
    logic [63:0] value;
    logic [8:0]  position;
    logic [2:0]  status;
    logic        frame_ok;
    logic        final_res;
  } nsfp_res_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction
endpackage

[rtl/core/nsfp_front.sv]
// Front part: accepts frame bytes and holds back the four-byte trailer.
// Depends on nsfp_pkg.
module nsfp_front import nsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       req_valid,
  input  logic       req_ready,
  output nsfp_req_t  req
);
  logic [7:0] dly [4];
  logic [2:0] seen;
  logic       acc;

  assign in_ready = !req_valid || req_ready;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      req_valid <= 1'b0;
      for (int i = 0; i < 4; i++) dly[i] <= '0;
    end else begin
      if (req_valid && req_ready) req_valid <= 1'b0;
      if (acc) begin
        req_valid <= 1'b1;
        req.feed <= seen[2];
        req.leave <= dly[0];
        req.last <= last_byte;
        // The fourth byte completes the trailer, so only fewer than four is short.
        req.short_fr <= last_byte && (seen < 3'd3);
        req.rx_crc <= seen[2] ? {data_byte, dly[3], dly[2], dly[1]}
                              : {data_byte, dly[2], dly[1], dly[0]};
        if (last_byte) begin
          seen <= '0;
          for (int i = 0; i < 4; i++) dly[i] <= '0;
        end else if (seen[2]) begin
          dly[0] <= dly[1];
          dly[1] <= dly[2];
          dly[2] <= dly[3];
          dly[3] <= data_byte;
        end else begin
          dly[seen[1:0]] <= data_byte;
          seen <= seen + 3'd1;
        end
      end
    end
  end
endmodule

[rtl/core/nsfp_queue.sv]
// Short queue between front and back parts.
// Depends on nsfp_pkg.
module nsfp_queue import nsfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  nsfp_req_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output nsfp_req_t rd_data
);
  nsfp_req_t mem [2];
  logic      wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      cnt <= cnt + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule

[rtl/core/nsfp_back.sv]
// Back part: CRC, field parser and result output with skid stage.
// Depends on nsfp_pkg and the assertion macro header.
`include "note_snapshot_frame_parser_top_defines.svh"
module nsfp_back import nsfp_pkg::*; #(
  parameter int MAX_NOTES = 32,
  parameter int MAX_TITLE_BYTES = 64,
  parameter int MAX_BODY_BYTES = 512,
  parameter int MAX_REMINDER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] expected_schema,
  input  logic        req_valid,
  output logic        req_ready,
  input  nsfp_req_t   req,
  output logic        res_valid,
  input  logic        res_ready,
  output nsfp_res_t   res
);
  typedef enum logic [3:0] {
    SEC_SCHEMA = 4'd0, SEC_VERSION = 4'd1, SEC_COUNT = 4'd2, SEC_LEN0 = 4'd3,
    SEC_LEN1 = 4'd4, SEC_LEN2 = 4'd5, SEC_ORDER = 4'd6, SEC_TIME = 4'd7,
    SEC_FLAGS = 4'd8, SEC_TEXT0 = 4'd9, SEC_TEXT1 = 4'd10, SEC_TEXT2 = 4'd11,
    SEC_DONE = 4'd12
  } sec_t;

  sec_t        sec, sec_next;
  logic [31:0] crc, crc_next;
  logic [3:0]  fcnt, fcnt_next;
  logic [63:0] facc, facc_next;
  logic [15:0] note, note_next, nexp, nexp_next, trem, trem_next;
  logic [15:0] tlen [3];
  logic [15:0] tlen_next [3];
  logic        cflag, cflag_next;
  logic [2:0]  err, err_next;

  // Two-entry output buffer; one request yields at most two results.
  nsfp_res_t   ob [2];
  logic        orp;
  logic [1:0]  ocnt;
  nsfp_res_t   r0, r1;
  logic [1:0]  nres;
  logic        take;

  assign res_valid = ocnt != 2'd0;
  assign res = ob[orp];
  assign req_ready = ocnt == 2'd0 || (ocnt == 2'd1 && res_ready);
  assign take = req_valid && req_ready;

  function automatic logic [15:0] tmax(logic [1:0] k);
    case (k)
      2'd0: tmax = 16'(MAX_TITLE_BYTES);
      2'd1: tmax = 16'(MAX_BODY_BYTES);
      default: tmax = 16'(MAX_REMINDER_BYTES);
    endcase
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        emit;
    logic [3:0]  need;
    logic [63:0] v;
    logic [1:0]  k;
    logic        go;
    logic [2:0]  st;
    sec_next = sec; crc_next = crc; fcnt_next = fcnt; facc_next = facc;
    note_next = note; nexp_next = nexp; trem_next = trem;
    for (int i = 0; i < 3; i++) tlen_next[i] = tlen[i];
    cflag_next = cflag; err_next = err;
    r0 = '0; r1 = '0; emit = 1'b0; go = 1'b0; k = 2'd0;
    b = req.leave; v = '0; st = ST_OK;
    need = (sec == SEC_VERSION || sec == SEC_TIME) ? 4'd8 : 4'd2;
    r0.note_index = note[4:0];
    if (req.feed) begin
      crc_next = crc_byte(crc, b);
      if (err != ST_OK) begin
      end else if (sec == SEC_DONE) begin
        err_next = ST_TRAIL;
      end else if (sec >= SEC_TEXT0) begin
        k = 2'(sec - SEC_TEXT0);
        emit = 1'b1;
        r0.kind = KIND_TEXT0 + {2'd0, k};
        r0.value = {56'd0, b};
        r0.position = 9'(tlen[k] - trem);
        trem_next = trem - 16'd1;
        if (trem == 16'd1) begin
          go = 1'b1;
          k = k + 2'd1;
        end
      end else if (sec == SEC_FLAGS) begin
        if (fcnt == 4'd0) begin
          cflag_next = b != 8'd0;
          fcnt_next = 4'd1;
        end else begin
          fcnt_next = 4'd0;
          emit = 1'b1;
          r0.kind = KIND_FLAGS;
          r0.value = {62'd0, b != 8'd0, cflag};
          go = 1'b1;
        end
      end else begin
        v = facc | ({56'd0, b} << {fcnt[2:0], 3'd0});
        facc_next = v;
        fcnt_next = fcnt + 4'd1;
        if (fcnt + 4'd1 >= need) begin
          facc_next = '0;
          fcnt_next = '0;
          r0.value = v;
          case (sec)
            SEC_SCHEMA: begin
              if (v[15:0] != expected_schema) err_next = ST_SCHEMA;
              else sec_next = SEC_VERSION;
            end
            SEC_VERSION: begin
              emit = 1'b1; r0.kind = KIND_VERSION; r0.note_index = '0;
              sec_next = SEC_COUNT;
            end
            SEC_COUNT: begin
              if (v[15:0] > 16'(MAX_NOTES)) err_next = ST_COUNT;
              else begin
                nexp_next = v[15:0];
                note_next = '0;
                emit = 1'b1; r0.kind = KIND_COUNT; r0.note_index = '0;
                sec_next = (v[15:0] == 16'd0) ? SEC_DONE : SEC_LEN0;
              end
            end
            SEC_ORDER: begin
              emit = 1'b1; r0.kind = KIND_ORDER; sec_next = SEC_TIME;
            end
            SEC_TIME: begin
              emit = 1'b1; r0.kind = KIND_TIME; sec_next = SEC_FLAGS;
            end
            default: begin
              k = 2'(sec - SEC_LEN0);
              tlen_next[k] = v[15:0];
              emit = 1'b1; r0.kind = KIND_LEN0 + {2'd0, k};
              sec_next = sec_t'(sec + 4'd1);
              k = 2'd0;
            end
          endcase
        end
      end
      // Start the next non-empty text run, flag an overlong run, or close the note.
      if (go) begin
        if (k <= 2'd0 && tlen_next[0] > tmax(2'd0)) err_next = ST_LONG;
        else if (k <= 2'd0 && tlen_next[0] != 16'd0) begin
          sec_next = SEC_TEXT0; trem_next = tlen_next[0];
        end else if (k <= 2'd1 && tlen_next[1] > tmax(2'd1)) err_next = ST_LONG;
        else if (k <= 2'd1 && tlen_next[1] != 16'd0) begin
          sec_next = SEC_TEXT1; trem_next = tlen_next[1];
        end else if (k <= 2'd2 && tlen_next[2] > tmax(2'd2)) err_next = ST_LONG;
        else if (k <= 2'd2 && tlen_next[2] != 16'd0) begin
          sec_next = SEC_TEXT2; trem_next = tlen_next[2];
        end else begin
          note_next = note + 16'd1;
          sec_next = (note + 16'd1 >= nexp) ? SEC_DONE : SEC_LEN0;
        end
      end
    end
    if (req.last) begin
      if (req.short_fr) st = ST_SHORT;
      else if (~crc_next != req.rx_crc) st = ST_CRC;
      else if (err_next != ST_OK) st = err_next;
      else if (sec_next != SEC_DONE) st = ST_TRUNC;
      else st = ST_OK;
      r1 = '0;
      r1.kind = KIND_STATUS;
      r1.status = st;
      r1.frame_ok = st == ST_OK;
      r1.final_res = 1'b1;
      sec_next = SEC_SCHEMA; crc_next = CRC_INIT; fcnt_next = '0; facc_next = '0;
      note_next = '0; nexp_next = '0; trem_next = '0; cflag_next = 1'b0;
      err_next = ST_OK;
      for (int i = 0; i < 3; i++) tlen_next[i] = '0;
    end else begin
      r0.final_res = 1'b1;
    end
    if (emit && req.last) nres = 2'd2;
    else if (emit) nres = 2'd1;
    else if (req.last) begin
      nres = 2'd1; r0 = r1;
    end else nres = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec <= SEC_SCHEMA; crc <= CRC_INIT; fcnt <= '0; facc <= '0;
      note <= '0; nexp <= '0; trem <= '0; cflag <= 1'b0; err <= ST_OK;
      for (int i = 0; i < 3; i++) tlen[i] <= '0;
      orp <= 1'b0; ocnt <= '0;
    end else begin
      if (take) begin
        sec <= sec_next; crc <= crc_next; fcnt <= fcnt_next; facc <= facc_next;
        note <= note_next; nexp <= nexp_next; trem <= trem_next;
        cflag <= cflag_next; err <= err_next;
        for (int i = 0; i < 3; i++) tlen[i] <= tlen_next[i];
      end
      if (take && nres != 2'd0) begin
        // Buffer is empty or drains its single entry this cycle.
        ob[0] <= r0;
        ob[1] <= r1;
        orp <= 1'b0;
        ocnt <= nres;
      end else if (res_valid && res_ready) begin
        orp <= !orp;
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  `NSFP_ASSERT_IMP(a_buf_bound, 1'b1, ocnt != 2'd3)
  `NSFP_ASSERT_IMP(a_status_last, res_valid && res.kind == KIND_STATUS, res.final_res)
  `NSFP_ASSERT_NEXT(a_frame_clear, take && req.last, sec == SEC_SCHEMA && err == ST_OK)
endmodule

[rtl/core/note_snapshot_frame_parser_top.sv]
// Top level of the note snapshot frame parser.
// Depends on nsfp_pkg, nsfp_front, nsfp_queue and nsfp_back.
//
// Takes one frame byte per cycle on the s_axis side while tready is high, with tlast
// on the final byte. The last four bytes of a frame are the reflected CRC-32
// trailer; every earlier byte feeds the CRC and a little-endian field parser.
// Each completed field but the schema and each text byte leaves as one request on
// m_axis; the final byte adds a status request (tuser = frame_ok, tlast = last
// result of an input byte). Throughput is one byte per cycle while the output is
// taken; a byte that ends a frame after a field makes two output requests and so
// holds the back part until the first is taken, which the two-entry queue absorbs.
// From input to first result a byte passes the front register, queue and output buffer.
module note_snapshot_frame_parser_top import nsfp_pkg::*; #(
  parameter int MAX_NOTES = 32,
  parameter int MAX_TITLE_BYTES = 64,
  parameter int MAX_BODY_BYTES = 512,
  parameter int MAX_REMINDER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] kind, [8:4] note_index, [72:9] value, [81:73] position, [84:82] status
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,   // frame_ok
  output logic        m_axis_tlast    // final_res
);
  logic [15:0] expected_schema;
  logic        f_valid, f_ready, q_valid, q_ready;
  nsfp_req_t   f_req, q_req;
  nsfp_res_t   res;

  always_ff @(posedge clk) begin
    if (rst) expected_schema <= 16'd1;
    else if (cfg_we) expected_schema <= cfg_wdata;
  end

  nsfp_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .last_byte(s_axis_tlast),
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  nsfp_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  nsfp_back #(
    .MAX_NOTES(MAX_NOTES), .MAX_TITLE_BYTES(MAX_TITLE_BYTES),
    .MAX_BODY_BYTES(MAX_BODY_BYTES), .MAX_REMINDER_BYTES(MAX_REMINDER_BYTES)
  ) u_back (
    .clk, .rst, .expected_schema,
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {3'd0, res.status, res.position, res.value,
                         res.note_index, res.kind};
  assign m_axis_tuser = res.frame_ok;
  assign m_axis_tlast = res.final_res;
endmodule

[sim/note_snapshot_frame_parser_top_tb.sv]
// Self-checking testbench for the note snapshot frame parser top level.
// Depends on nsfp_pkg and note_snapshot_frame_parser_top; builds CRC-32 framed
// note snapshots, predicts every field, text byte and status, and compares.
`timescale 1ns / 1ps
module note_snapshot_frame_parser_top_tb;
  import nsfp_pkg::*;

  localparam int NOTE_LIMIT = 32;
  localparam int TITLE_LIMIT = 64;
  localparam int BODY_LIMIT = 512;
  localparam int REMIND_LIMIT = 64;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_BYTES = 320;

  // Parser position inside the frame payload.
  typedef enum int {
    SEC_SCHEMA, SEC_VERSION, SEC_COUNT, SEC_LEN0, SEC_LEN1, SEC_LEN2,
    SEC_ORDER, SEC_TIME, SEC_FLAGS, SEC_TEXT0, SEC_TEXT1, SEC_TEXT2, SEC_DONE
  } parse_sec_e;

  // Frame variants built by the stimulus generator.
  typedef enum int {
    FR_GOOD, FR_BAD_CRC, FR_BAD_SCHEMA, FR_BAD_COUNT, FR_TEXT_LONG,
    FR_TRUNC, FR_TRAIL, FR_SHORT, FR_NOISE
  } frame_kind_e;

  // Predicts the parser output and holds the results still owed by the block.
  class note_frame_scoreboard;
    bit [15:0]  schema_cfg;
    bit [7:0]   delay[4];
    int         seen;
    bit [31:0]  crc;
    parse_sec_e sec;
    int         fbc;
    bit [63:0]  acc;
    bit [15:0]  note;
    bit [15:0]  nexp;
    bit [15:0]  tlen[3];
    bit [15:0]  trem;
    bit         cflag;
    bit [2:0]   err;
    nsfp_res_t  step_out[$];
    nsfp_res_t  owed_q[$];
    int         mismatches;

    function new();
      schema_cfg = 16'd1;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (delay[i]) delay[i] = 8'd0;
      foreach (tlen[i]) tlen[i] = 16'd0;
      seen = 0;
      crc = 32'hFFFFFFFF;
      sec = SEC_SCHEMA;
      fbc = 0;
      acc = 64'd0;
      note = 16'd0;
      nexp = 16'd0;
      trem = 16'd0;
      cflag = 1'b0;
      err = ST_OK;
    endfunction

    function void add(logic [3:0] kind, bit [63:0] value, bit [15:0] pos,
                      logic [2:0] st);
      nsfp_res_t r;
      r.kind = kind;
      r.note_index = (kind == KIND_STATUS || kind <= KIND_COUNT) ? 5'd0 : note[4:0];
      r.value = value;
      r.position = pos[8:0];
      r.status = st;
      r.frame_ok = (kind == KIND_STATUS && st == ST_OK);
      r.final_res = 1'b0;
      step_out = {step_out, r};
    endfunction

    function int text_max(int k);
      if (k == 0) return TITLE_LIMIT;
      if (k == 1) return BODY_LIMIT;
      return REMIND_LIMIT;
    endfunction

    // Start run k or the next non-empty one, or flag an overlong run; otherwise close the note.
    function void begin_text(int k);
      for (int j = k; j < 3; j++) begin
        if (tlen[j] > text_max(j)) begin
          err = ST_LONG;
          return;
        end
        if (tlen[j] > 0) begin
          sec = parse_sec_e'(SEC_TEXT0 + j);
          trem = tlen[j];
          return;
        end
      end
      note = note + 16'd1;
      sec = (note >= nexp) ? SEC_DONE : SEC_LEN0;
    endfunction

    function void parse(bit [7:0] b);
      int need;
      int k;
      bit [63:0] v;
      if (err != ST_OK) return;
      if (sec == SEC_DONE) begin
        err = ST_TRAIL;
        return;
      end
      if (sec >= SEC_TEXT0) begin
        k = sec - SEC_TEXT0;
        add(KIND_TEXT0 + 4'(k), 64'(b), tlen[k] - trem, ST_OK);
        trem = trem - 16'd1;
        if (trem == 0) begin_text(k + 1);
        return;
      end
      if (sec == SEC_FLAGS) begin
        if (fbc == 0) begin
          cflag = (b != 0);
          fbc = 1;
          return;
        end
        fbc = 0;
        add(KIND_FLAGS, {62'd0, (b != 0), cflag}, 16'd0, ST_OK);
        begin_text(0);
        return;
      end
      need = (sec == SEC_VERSION || sec == SEC_TIME) ? 8 : 2;
      acc |= 64'(b) << (8 * fbc);
      fbc++;
      if (fbc < need) return;
      v = acc;
      acc = 64'd0;
      fbc = 0;
      case (sec)
        SEC_SCHEMA: begin
          if (v != 64'(schema_cfg)) err = ST_SCHEMA;
          else sec = SEC_VERSION;
        end
        SEC_VERSION: begin
          add(KIND_VERSION, v, 16'd0, ST_OK);
          sec = SEC_COUNT;
        end
        SEC_COUNT: begin
          if (v > NOTE_LIMIT) err = ST_COUNT;
          else begin
            nexp = v[15:0];
            note = 16'd0;
            add(KIND_COUNT, v, 16'd0, ST_OK);
            sec = (v == 0) ? SEC_DONE : SEC_LEN0;
          end
        end
        SEC_ORDER: begin
          add(KIND_ORDER, v, 16'd0, ST_OK);
          sec = SEC_TIME;
        end
        SEC_TIME: begin
          add(KIND_TIME, v, 16'd0, ST_OK);
          sec = SEC_FLAGS;
        end
        default: begin
          k = sec - SEC_LEN0;
          tlen[k] = v[15:0];
          add(KIND_LEN0 + 4'(k), v, 16'd0, ST_OK);
          sec = parse_sec_e'(sec + 1);
        end
      endcase
    endfunction

    // Advance the prediction by one accepted request.
    function void note_input(bit [7:0] b, bit last);
      bit [7:0] leave;
      bit [31:0] rx;
      logic [2:0] st;
      step_out.delete();
      if (seen >= 4) begin
        leave = delay[0];
        delay[0] = delay[1];
        delay[1] = delay[2];
        delay[2] = delay[3];
        delay[3] = b;
        crc ^= 32'(leave);
        for (int i = 0; i < 8; i++) crc = (crc >> 1) ^ (crc[0] ? 32'hEDB88320 : 32'd0);
        parse(leave);
      end else begin
        delay[seen] = b;
        seen++;
      end
      if (last) begin
        rx = {delay[3], delay[2], delay[1], delay[0]};
        if (seen < 4) st = ST_SHORT;
        else if (~crc != rx) st = ST_CRC;
        else if (err != ST_OK) st = err;
        else if (sec != SEC_DONE) st = ST_TRUNC;
        else st = ST_OK;
        add(KIND_STATUS, 64'd0, 16'd0, st);
        clear();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].final_res = 1'b1;
      foreach (step_out[i]) owed_q = {owed_q, step_out[i]};
    endfunction

    function void check_result(nsfp_res_t got);
      nsfp_res_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: kind %0d note %0d value %h status %0d",
                   $realtime, got.kind, got.note_index, got.value, got.status);
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result differs: expected kind %0d note %0d value %h pos %0d ",
                    "st %0d ok %0b fin %0b, got kind %0d note %0d value %h pos %0d ",
                    "st %0d ok %0b fin %0b"}, $realtime,
                   want.kind, want.note_index, want.value, want.position, want.status,
                   want.frame_ok, want.final_res, got.kind, got.note_index, got.value,
                   got.position, got.status, got.frame_ok, got.final_res);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  note_frame_scoreboard sb = new();
  bit [7:0] frame_q[$];
  bit       calm;
  int       cycles = 0;
  int       sent = 0;

  note_snapshot_frame_parser_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; calm frames have none.
  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Sample every accepted result at the rising edge.
  always @(posedge clk) begin
    nsfp_res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[3:0];
      got.note_index = m_axis_tdata[8:4];
      got.value = m_axis_tdata[72:9];
      got.position = m_axis_tdata[81:73];
      got.status = m_axis_tdata[84:82];
      got.frame_ok = m_axis_tuser;
      got.final_res = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // Result side back-pressure: a zero gap raises tready, any other gap stalls for that gap.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_byte(bit [7:0] b, bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(b, last);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    calm = ($urandom_range(0, 3) == 0);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Wait for every owed result, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.owed_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_schema(bit [15:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.schema_cfg = v;
  endtask

  // Append one byte to the frame under construction.
  function void put_byte(bit [7:0] v);
    frame_q = {frame_q, v};
  endfunction

  function void push_le(bit [63:0] v, int n);
    for (int i = 0; i < n; i++) put_byte(v[8 * i +: 8]);
  endfunction

  // Append the reflected CRC-32 of the payload built so far.
  function void seal();
    bit [31:0] c;
    c = 32'hFFFFFFFF;
    foreach (frame_q[i]) begin
      c ^= 32'(frame_q[i]);
      for (int j = 0; j < 8; j++) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
    end
    push_le(64'(~c), 4);
  endfunction

  function int pick_len(int k, bit too_long);
    int lim;
    lim = (k == 0) ? TITLE_LIMIT : (k == 1) ? BODY_LIMIT : REMIND_LIMIT;
    if (too_long) return lim + $urandom_range(1, 3) * (($urandom_range(0, 3) == 0) ? 999 : 1);
    if ($urandom_range(0, 29) == 0) return lim;
    if (k == 1 && $urandom_range(0, 9) == 0) return $urandom_range(9, 40);
    return $urandom_range(0, 6);
  endfunction

  // Build one frame of the given variant into frame_q.
  function void build_frame(frame_kind_e fk);
    int count;
    int bad_note;
    int bad_run;
    int len[3];
    frame_q.delete();
    if (fk == FR_SHORT) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      return;
    end
    if (fk == FR_NOISE) begin
      repeat ($urandom_range(4, 30)) put_byte(8'($urandom));
      return;
    end
    push_le(fk == FR_BAD_SCHEMA ? 64'(sb.schema_cfg ^ 16'($urandom_range(1, 65535)))
                                : 64'(sb.schema_cfg), 2);
    push_le({$urandom, $urandom}, 8);
    if (fk == FR_BAD_COUNT) begin
      push_le(64'($urandom_range(NOTE_LIMIT + 1, 65535)), 2);
      repeat ($urandom_range(0, 20)) put_byte(8'($urandom));
      seal();
      return;
    end
    count = ($urandom_range(0, 29) == 0) ? NOTE_LIMIT : $urandom_range(0, 3);
    if (fk == FR_TEXT_LONG && count == 0) count = 1;
    bad_note = $urandom_range(0, count - 1);
    bad_run = $urandom_range(0, 2);
    push_le(64'(count), 2);
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        len[k] = (count == NOTE_LIMIT) ? 0
                 : pick_len(k, fk == FR_TEXT_LONG && n == bad_note && k == bad_run);
        push_le(64'(len[k]), 2);
      end
      push_le(64'($urandom_range(0, 65535)), 2);
      push_le({$urandom, $urandom}, 8);
      put_byte($urandom_range(0, 1) ? 8'($urandom) : 8'd0);
      put_byte($urandom_range(0, 1) ? 8'($urandom) : 8'd0);
      for (int k = 0; k < 3; k++)
        repeat (len[k] > 600 ? 3 : len[k]) put_byte(8'($urandom));
    end
    if (fk == FR_TRUNC && frame_q.size() > 1)
      repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
    if (fk == FR_TRAIL) repeat ($urandom_range(1, 5)) put_byte(8'($urandom));
    seal();
    if (fk == FR_BAD_CRC) frame_q[frame_q.size() - 1 - $urandom_range(0, 3)] ^=
                          8'(1 << $urandom_range(0, 7));
  endfunction

  function frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return FR_GOOD;
    if (r < 65) return FR_BAD_CRC;
    if (r < 70) return FR_BAD_SCHEMA;
    if (r < 75) return FR_BAD_COUNT;
    if (r < 81) return FR_TEXT_LONG;
    if (r < 87) return FR_TRUNC;
    if (r < 92) return FR_TRAIL;
    if (r < 96) return FR_SHORT;
    return FR_NOISE;
  endfunction

  initial begin
    bit [15:0] schemas[4];
    int target;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: short frames, an empty payload, and a bare header with extreme version.
    write_schema(16'd1);
    calm = 1'b1;
    for (int n = 1; n <= 4; n++) begin
      frame_q.delete();
      repeat (n) put_byte(n == 4 ? 8'h00 : 8'hFF);
      send_frame();
    end
    frame_q.delete();
    push_le(64'd1, 2);
    push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    push_le(64'd0, 2);
    seal();
    send_frame();

    // Random frames under several schema settings, the extremes among them.
    schemas[0] = 16'd0;
    schemas[1] = 16'hFFFF;
    schemas[2] = 16'($urandom);
    schemas[3] = 16'd1;
    foreach (schemas[p]) begin
      write_schema(schemas[p]);
      target = sent + PHASE_BYTES;
      while (sent < target) begin
        build_frame(pick_kind());
        send_frame();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/nsfp_pkg.sv
rtl/core/nsfp_front.sv
rtl/core/nsfp_queue.sv
rtl/core/nsfp_back.sv
rtl/core/note_snapshot_frame_parser_top.sv
sim/note_snapshot_frame_parser_top_tb.sv
